### src/drd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drd_pkg: shared types for the delta record decoder
// Parser phase codes and the record word passed from parser to line stage.
// ----------------------------------------------------------------------------
package drd_pkg;

	// parser phase, one-hot
	typedef enum logic [3:0] {
		PH_CTRL = 4'b0001,
		PH_SRC  = 4'b0010,
		PH_CNT  = 4'b0100,
		PH_SKIP = 4'b1000
	} phase_t;

	localparam int unsigned FieldW = 32;
	localparam int unsigned LeftW  = 3;

	// completed record, before the line counter is applied
	typedef struct packed {
		logic [FieldW-1:0] source;
		logic [FieldW-1:0] count;
		logic [FieldW-1:0] skip;
	} rec_t;

	// parser to line stage control
	typedef struct packed {
		logic valid;
	} rec_ctl_t;

endpackage
`default_nettype wire

### src/drd_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drd_parse: record byte parser
// Walks control, source, count and skip fields one byte per cycle when not
// stalled, and registers each completed record into stage 1.
// ----------------------------------------------------------------------------
module drd_parse (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire logic [7:0]          delta_byte,
	input  wire logic                rec_adv,
	output drd_pkg::rec_ctl_t        rec_ctl,
	output drd_pkg::rec_t            rec
);

	drd_pkg::phase_t                  phase_q, phase_d;
	logic [drd_pkg::LeftW-1:0]        left_q, left_d;
	logic [4:0]                       ctl_q, ctl_d;       // control bits 5:1
	logic [drd_pkg::FieldW-1:0]       src_q, src_d;
	logic [drd_pkg::FieldW-1:0]       cnt_q, cnt_d;
	logic [drd_pkg::FieldW-1:0]       skip_q, skip_d;
	logic                             fin;
	logic                             accept;
	logic                             rec_valid_s1;
	drd_pkg::rec_t                    rec_s1;
	logic [drd_pkg::LeftW-1:0]        left_dec;

	// stall only while a finished record is still parked in stage 1
	assign byte_stall = rec_valid_s1 && !rec_adv;
	assign accept     = byte_valid && !byte_stall;
	assign left_dec   = left_q - drd_pkg::LeftW'(1);

	// next-state of the field walk
	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		ctl_d   = ctl_q;
		src_d   = src_q;
		cnt_d   = cnt_q;
		skip_d  = skip_q;
		fin     = 1'b0;
		unique case (phase_q)
			drd_pkg::PH_CTRL: begin
				ctl_d   = delta_byte[5:1];
				src_d   = '0;
				cnt_d   = '0;
				skip_d  = '0;
				left_d  = {1'b0, delta_byte[7:6]} + drd_pkg::LeftW'(1);
				phase_d = drd_pkg::PH_SRC;
			end
			drd_pkg::PH_SRC: begin
				src_d  = {src_q[drd_pkg::FieldW-9:0], delta_byte};
				left_d = left_dec;
				if (left_dec == '0) begin
					left_d  = {1'b0, ctl_q[4:3]} + drd_pkg::LeftW'(1);
					phase_d = drd_pkg::PH_CNT;
				end
			end
			drd_pkg::PH_CNT: begin
				cnt_d  = {cnt_q[drd_pkg::FieldW-9:0], delta_byte};
				left_d = left_dec;
				if (left_dec == '0) begin
					if (ctl_q[0]) begin
						left_d  = {1'b0, ctl_q[2:1]} + drd_pkg::LeftW'(1);
						phase_d = drd_pkg::PH_SKIP;
					end else begin
						fin     = 1'b1;
						phase_d = drd_pkg::PH_CTRL;
					end
				end
			end
			drd_pkg::PH_SKIP: begin
				skip_d = {skip_q[drd_pkg::FieldW-9:0], delta_byte};
				left_d = left_dec;
				if (left_dec == '0) begin
					fin     = 1'b1;
					phase_d = drd_pkg::PH_CTRL;
				end
			end
			default: begin
				phase_d = drd_pkg::PH_CTRL;
				left_d  = '0;
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= drd_pkg::PH_CTRL;
			left_q  <= '0;
			ctl_q   <= '0;
			src_q   <= '0;
			cnt_q   <= '0;
			skip_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			ctl_q   <= ctl_d;
			src_q   <= src_d;
			cnt_q   <= cnt_d;
			skip_q  <= skip_d;
		end
	end

	// stage 1 record register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_s1 <= 1'b0;
		end else if (accept && fin) begin
			rec_valid_s1 <= 1'b1;
		end else if (rec_adv) begin
			rec_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && fin) begin
			rec_s1.source <= src_d;
			rec_s1.count  <= cnt_d;
			rec_s1.skip   <= skip_d;
		end
	end

	assign rec_ctl.valid = rec_valid_s1;
	assign rec           = rec_s1;

	// a fresh record only comes out of a count or skip field
	a_fin_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fin) |-> (phase_q == drd_pkg::PH_CNT || phase_q == drd_pkg::PH_SKIP))
		else $error("record finished outside count/skip field");

	a_ctrl_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == drd_pkg::PH_CTRL) |-> (left_q == '0))
		else $error("bytes left nonzero while expecting control byte");

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != drd_pkg::PH_CTRL) |-> (left_q != '0 && left_q <= drd_pkg::LeftW'(4)))
		else $error("field byte count out of range");

endmodule
`default_nettype wire

### src/drd_line.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drd_line: line counter and result register
// Adds skip to the running line, emits the record, then adds the count or
// clears the counter at end of list.
// ----------------------------------------------------------------------------
module drd_line (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire drd_pkg::rec_ctl_t          rec_ctl,
	input  wire drd_pkg::rec_t              rec,
	output logic                            rec_adv,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [drd_pkg::FieldW-1:0]      source_block,
	output logic [drd_pkg::FieldW-1:0]      block_count,
	output logic [drd_pkg::FieldW-1:0]      target_line,
	output logic                            list_end
);

	logic [drd_pkg::FieldW-1:0] line_q;
	logic [drd_pkg::FieldW-1:0] target;
	logic                       last;
	logic                       out_valid_q;
	logic [drd_pkg::FieldW-1:0] src_q, cnt_q, tgt_q;
	logic                       end_q;

	assign target  = line_q + rec.skip;
	assign last    = (rec.count == '0);
	// output register is free when empty or being taken this cycle
	assign rec_adv = rec_ctl.valid && (!out_valid_q || !out_stall);

	// running line counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (rec_adv) begin
			line_q <= last ? '0 : (target + rec.count);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_adv) begin
			src_q <= rec.source;
			cnt_q <= rec.count;
			tgt_q <= target;
			end_q <= last;
		end
	end

	assign out_valid    = out_valid_q;
	assign source_block = src_q;
	assign block_count  = cnt_q;
	assign target_line  = tgt_q;
	assign list_end     = end_q;

	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_adv && last) |=> (line_q == '0))
		else $error("line counter not cleared after end of list");

	a_line_step: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_adv && !last) |=> (line_q == $past(line_q + rec.skip + rec.count)))
		else $error("line counter step wrong");

	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (end_q == (cnt_q == '0)))
		else $error("list_end disagrees with block_count");

endmodule
`default_nettype wire

### src/delta_record_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delta_record_decoder_core: match-record list decoder
// Takes the record list one byte per word and emits each completed record
// with its target line.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless stalled; a record needs at least three bytes.
// A completed record passes through the stage 1 record reg, then the result
//   reg, before the result word is valid.
// Stall on the byte side rises only while stage 1 holds a record that the
//   stalled result register cannot take.
// Reset (arst_n low): parser expects a control byte, line counter is zero,
//   no result pending.
// ----------------------------------------------------------------------------
module delta_record_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  delta_byte,
	output logic             rec_valid,
	input  wire logic        rec_stall,
	output logic [31:0]      source_block,
	output logic [31:0]      block_count,
	output logic [31:0]      target_line,
	output logic             list_end
);

	drd_pkg::rec_ctl_t rec_ctl;
	drd_pkg::rec_t     rec;
	logic              rec_adv;

	drd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.delta_byte (delta_byte),
		.rec_adv    (rec_adv),
		.rec_ctl    (rec_ctl),
		.rec        (rec)
	);

	drd_line u_line (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_ctl      (rec_ctl),
		.rec          (rec),
		.rec_adv      (rec_adv),
		.out_valid    (rec_valid),
		.out_stall    (rec_stall),
		.source_block (source_block),
		.block_count  (block_count),
		.target_line  (target_line),
		.list_end     (list_end)
	);

endmodule
`default_nettype wire

### test/tb_delta_record_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delta_record_decoder_core: self-checking bench for the record decoder
// Feeds match-record lists one byte per word, tracks the parser and the line
// counter in a local decoder, and compares each emitted record field by field.
// Both handshakes idle at random in two idling phases; a third runs with no idling.
// ----------------------------------------------------------------------------
module tb_delta_record_decoder_core;

	localparam int CycleLimit = 200000;
	localparam int MaxPrinted = 40;

	// one decoded record as the block should emit it
	typedef struct packed {
		logic [31:0] source;
		logic [31:0] count;
		logic [31:0] target;
		logic        last;
	} record_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  delta_byte = 8'h00;
	logic        rec_valid;
	logic        rec_stall = 1'b0;
	logic [31:0] source_block;
	logic [31:0] block_count;
	logic [31:0] target_line;
	logic        list_end;

	// local decoder state
	drd_pkg::phase_t            dec_phase = drd_pkg::PH_CTRL;
	logic [drd_pkg::LeftW-1:0]  dec_left = '0;
	logic [7:0]                 dec_ctl = '0;
	logic [31:0]                dec_source = '0;
	logic [31:0]                dec_count = '0;
	logic [31:0]                dec_skip = '0;
	logic [31:0]                dec_line = '0;

	record_word_t pending_records[$];

	int send_idle_pct  = 0;
	int stall_pct      = 0;
	int errors         = 0;
	int cycles         = 0;
	int bytes_sent     = 0;
	int records_seen   = 0;
	int lists_ended    = 0;

	delta_record_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.delta_byte   (delta_byte),
		.rec_valid    (rec_valid),
		.rec_stall    (rec_stall),
		.source_block (source_block),
		.block_count  (block_count),
		.target_line  (target_line),
		.list_end     (list_end)
	);

	always #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d records outstanding", cycles,
				pending_records.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < MaxPrinted)
			$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// advance the decoder by one accepted byte; queue the record it completes
	function automatic void decode_byte(input logic [7:0] b);
		record_word_t rec;
		logic         done;
		done = 1'b0;
		case (dec_phase)
			drd_pkg::PH_CTRL: begin
				dec_ctl    = b;
				dec_source = '0;
				dec_count  = '0;
				dec_skip   = '0;
				dec_left   = {1'b0, b[7:6]} + drd_pkg::LeftW'(1);
				dec_phase  = drd_pkg::PH_SRC;
			end
			drd_pkg::PH_SRC: begin
				dec_source = {dec_source[23:0], b};
				dec_left   = dec_left - drd_pkg::LeftW'(1);
				if (dec_left == '0) begin
					dec_left  = {1'b0, dec_ctl[5:4]} + drd_pkg::LeftW'(1);
					dec_phase = drd_pkg::PH_CNT;
				end
			end
			drd_pkg::PH_CNT: begin
				dec_count = {dec_count[23:0], b};
				dec_left  = dec_left - drd_pkg::LeftW'(1);
				if (dec_left == '0) begin
					if (dec_ctl[1]) begin
						dec_left  = {1'b0, dec_ctl[3:2]} + drd_pkg::LeftW'(1);
						dec_phase = drd_pkg::PH_SKIP;
					end else begin
						done = 1'b1;
					end
				end
			end
			default: begin
				dec_skip = {dec_skip[23:0], b};
				dec_left = dec_left - drd_pkg::LeftW'(1);
				if (dec_left == '0)
					done = 1'b1;
			end
		endcase
		if (done) begin
			// skip lands first, then the count advances the line
			dec_line   = dec_line + dec_skip;
			rec.source = dec_source;
			rec.count  = dec_count;
			rec.target = dec_line;
			rec.last   = (dec_count == '0);
			dec_line   = rec.last ? 32'd0 : dec_line + dec_count;
			dec_phase  = drd_pkg::PH_CTRL;
			dec_left   = '0;
			pending_records.push_back(rec);
		end
	endfunction

	// send one byte word, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		delta_byte <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		decode_byte(b);
		bytes_sent++;
	endtask

	// big-endian field of nbytes bytes
	task automatic send_field(input logic [31:0] v, input int nbytes);
		for (int i = nbytes - 1; i >= 0; i--)
			send_byte(v[8*i +: 8]);
	endtask

	// hold off the sender until every queued record has come out
	task automatic wait_drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value(input int nbytes);
		logic [31:0] v;
		case ($urandom_range(7))
			0: v = '0;
			1: v = '1;
			default: v = $urandom;
		endcase
		if (nbytes < 4)
			v = v & ((32'd1 << (8 * nbytes)) - 32'd1);
		return v;
	endfunction

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	// result side: random stall, check each accepted record
	always @(posedge clk) begin
		record_word_t want;
		if (arst_n && rec_valid && !rec_stall) begin
			if (pending_records.size() == 0) begin
				report_mismatch("unexpected record, source_block", source_block, 32'h0);
			end else begin
				want = pending_records.pop_front();
				if (source_block !== want.source)
					report_mismatch("source_block", source_block, want.source);
				if (block_count !== want.count)
					report_mismatch("block_count", block_count, want.count);
				if (target_line !== want.target)
					report_mismatch("target_line", target_line, want.target);
				if (list_end !== want.last)
					report_mismatch("list_end", {31'b0, list_end}, {31'b0, want.last});
				records_seen++;
				if (want.last)
					lists_ended++;
			end
		end
		rec_stall <= ($urandom_range(99) < stall_pct);
	end

	// field extremes, ignored control bits, zero skip, wrap, list end and restart
	task automatic test_field_extremes();
		send_byte(8'h0D);            // bit 0 and bits 3:2 without skip flag
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'h03);            // skip field present, value zero
		send_field(32'h00, 1);
		send_field(32'h01, 1);
		send_field(32'h00, 1);
		send_byte(8'hFE);            // widest fields, skip wraps the line counter
		send_field(32'hFFFF_FFFF, 4);
		send_field(32'hFFFF_FFFF, 4);
		send_field(32'hFFFF_FFFF, 4);
		send_byte(8'h00);            // count zero closes the list
		send_byte(8'hAA);
		send_byte(8'h00);
		send_byte(8'h00);            // new list starts back at line zero
		send_byte(8'h55);
		send_byte(8'h01);
		wait_drain();
	endtask

	// well-formed records with random sizes and content
	task automatic test_record_stream(input int nbytes);
		logic [7:0]  ctl;
		logic [31:0] src;
		logic [31:0] cnt;
		logic [31:0] skp;
		int          stop_at;
		stop_at = bytes_sent + nbytes;
		while (bytes_sent < stop_at) begin
			ctl = $urandom_range(255);
			src = pick_value(int'(ctl[7:6]) + 1);
			cnt = pick_value(int'(ctl[5:4]) + 1);
			skp = pick_value(int'(ctl[3:2]) + 1);
			if ($urandom_range(9) == 0)
				cnt = '0;
			send_byte(ctl);
			send_field(src, int'(ctl[7:6]) + 1);
			send_field(cnt, int'(ctl[5:4]) + 1);
			if (ctl[1])
				send_field(skp, int'(ctl[3:2]) + 1);
		end
		wait_drain();
	endtask

	// raw random bytes, no record framing from the sender
	task automatic test_byte_noise(input int nbytes);
		for (int i = 0; i < nbytes; i++)
			send_byte($urandom_range(255));
		wait_drain();
	endtask

	initial begin
		set_idling(19, 68);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_record_stream(250);
		set_idling(68, 19);
		test_record_stream(250);
		set_idling(0, 0);
		test_record_stream(250);
		test_byte_noise(100);

		byte_valid <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d bytes, checked %0d records across %0d closed lists",
			bytes_sent, records_seen, lists_ended);
		$display("covered field widths 1-4, skip on/off, line wrap, three idling phases");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
